// File: rtl/core/assert_macros.svh
// Assertion macros used by the allocator core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FFPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FFPA_NEVER(lbl, cond, msg) \
  `FFPA_ASSERT(lbl, !(cond), msg)
`else
`define FFPA_ASSERT(lbl, prop, msg)
`define FFPA_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/core/ffpa_pkg.sv
// Shared widths, codes and table entry types of the partition allocator.
package ffpa_pkg;
  localparam int LEN_W  = 13;
  localparam int OFF_W  = 12;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int SZ_W   = 14;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFIT    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] len;
  } ent_data_t;

  typedef struct packed {
    ent_data_t data;
    logic      used;
  } ent_t;

  typedef struct packed {
    logic      d_we;
    logic      u_we;
    ent_data_t data;
    logic      used;
  } tbl_wr_t;
endpackage

// File: rtl/core/ffpa_req_if.sv
// Request channel interface of the allocator.
interface ffpa_req_if;
  logic                       valid;
  logic                       ready;
  logic [ffpa_pkg::FUNC_W-1:0] func;
  logic [ffpa_pkg::LEN_W-1:0]  request_size;
  logic [ffpa_pkg::OFF_W-1:0]  free_offset;
  modport source (output valid, func, request_size, free_offset, input ready);
  modport sink (input valid, func, request_size, free_offset, output ready);
endinterface

// File: rtl/core/ffpa_rsp_if.sv
// Response channel interface of the allocator.
interface ffpa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [ffpa_pkg::OFF_W-1:0]  block_offset;
  logic [ffpa_pkg::STAT_W-1:0] status;
  modport source (output valid, block_offset, status, input ready);
  modport sink (input valid, block_offset, status, output ready);
endinterface

// File: rtl/core/first_fit_partition_allocator_core.sv
// First-fit partition allocator: request sequencer over the partition table.
//
// req_i carries one word per operation: allocate (request_size), free
// (free_offset) or reinitialise. rsp_o returns one word per request with
// block_offset and status. Both are valid/ready channels. cfg_we_i writes
// pool_length, which entry zero takes at the next reinitialise.
// One request is in flight at a time; a new one is taken in the cycle the
// last response leaves the output register.
// Allocate: granule rounding, then one RAM read per table entry scanned,
// then 1 to 2 writes, or a read and a write per entry moved up when a
// remainder is inserted. Free: one read per entry scanned, up to two
// neighbour reads, 1 to 3 writes and a read and a write per entry pulled
// down. The table RAM port takes one read and one write per cycle.
// Reset clears the valid bits of the table at once, so the table reads as
// freshly initialised with the full pool; no clearing pass is needed.
// A stalled receiver holds the response; the next request is then refused.
`include "assert_macros.svh"
module first_fit_partition_allocator_core #(
  parameter int TABLE_ENTRIES = 32,
  parameter int GRANULE       = 8,
  parameter int POOL_BYTES    = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ffpa_req_if.sink                    req_i,
  ffpa_rsp_if.source                  rsp_o,
  input  logic                        cfg_we_i,
  input  logic [ffpa_pkg::LEN_W-1:0]  cfg_wdata_i
);
  localparam int N  = TABLE_ENTRIES;
  localparam int IW = $clog2(N);
  localparam int LW = ffpa_pkg::LEN_W;
  localparam int SW = ffpa_pkg::SZ_W;
  localparam logic [LW-1:0] LIM = (POOL_BYTES > 8191) ? {LW{1'b1}} : LW'(POOL_BYTES);
  localparam logic signed [IW+1:0] NS   = (IW+2)'(N);
  localparam logic signed [IW+1:0] NM1  = (IW+2)'(N - 1);
  localparam logic signed [IW+1:0] NEG1 = '1;
  localparam logic signed [IW+1:0] ZERO = '0;
  localparam logic [IW-1:0] LAST = IW'(N - 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RND   = 5'd1;
  localparam logic [4:0] S_ARD   = 5'd2;
  localparam logic [4:0] S_ACHK  = 5'd3;
  localparam logic [4:0] S_ATAIL = 5'd4;
  localparam logic [4:0] S_SRD   = 5'd5;
  localparam logic [4:0] S_SWR   = 5'd6;
  localparam logic [4:0] S_GWI   = 5'd7;
  localparam logic [4:0] S_GWN   = 5'd8;
  localparam logic [4:0] S_FRD   = 5'd9;
  localparam logic [4:0] S_FCHK  = 5'd10;
  localparam logic [4:0] S_RRL   = 5'd11;
  localparam logic [4:0] S_RGL   = 5'd12;
  localparam logic [4:0] S_RRR   = 5'd13;
  localparam logic [4:0] S_RGR   = 5'd14;
  localparam logic [4:0] S_RACT  = 5'd15;
  localparam logic [4:0] S_RZR   = 5'd16;
  localparam logic [4:0] S_RWP   = 5'd17;
  localparam logic [4:0] S_PCHK  = 5'd18;
  localparam logic [4:0] S_PWR   = 5'd19;
  localparam logic [4:0] S_DONE  = 5'd20;

  logic [4:0]    st_q, st_d;
  logic [IW:0]   end_q, end_d;
  logic          ov_q, ov_d;
  logic [LW-1:0] pool_len_q;
  logic [LW-1:0] init_len_q, init_len_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] m_q, m_d;
  logic [SW-1:0] sz_q, sz_d;
  logic [LW-1:0] start_q, start_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] startl_q, startl_d;
  logic [LW-1:0] lenl_q, lenl_d;
  logic [LW-1:0] lenr_q, lenr_d;
  logic          lf_q, lf_d;
  logic          rf_q, rf_d;
  logic          wp_q, wp_d;
  logic signed [IW+1:0] k_q, k_d;
  logic signed [IW+1:0] pm_q, pm_d;
  logic [1:0]    gap_q, gap_d;
  logic [ffpa_pkg::OFF_W-1:0]  fo_q, fo_d;
  logic [ffpa_pkg::OFF_W-1:0]  res_off_q, res_off_d;
  logic [ffpa_pkg::STAT_W-1:0] res_st_q, res_st_d;

  logic                 in_acc;
  logic                 rd_en;
  logic [IW-1:0]        ra;
  logic [IW-1:0]        wa;
  ffpa_pkg::tbl_wr_t    wr;
  ffpa_pkg::ent_t       rd;
  logic                 tbl_clr;
  logic                 rnd_start;
  logic                 rnd_done;
  logic [SW-1:0]        rnd_sz;
  logic signed [IW+1:0] end_s;
  logic signed [IW+1:0] idx_s;
  logic signed [IW+1:0] e1;
  logic signed [IW+1:0] kg;

  assign in_acc      = req_i.valid && req_i.ready;
  assign req_i.ready = (st_q == S_IDLE) && (!ov_q || rsp_o.ready);
  assign rsp_o.valid = ov_q;
  assign rsp_o.block_offset = res_off_q;
  assign rsp_o.status = res_st_q;

  assign end_s = {end_q[IW], end_q};
  assign idx_s = {2'b00, idx_q};
  assign e1    = end_s + (IW+2)'(1);
  assign kg    = k_q + {{IW{1'b0}}, gap_q};

  ffpa_round #(.GRANULE(GRANULE)) u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rnd_start),
    .req_i   (req_i.request_size),
    .done_o  (rnd_done),
    .sz_o    (rnd_sz)
  );

  ffpa_table #(.N(N)) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (tbl_clr),
    .init_len_i (init_len_q),
    .re_i       (rd_en),
    .raddr_i    (ra),
    .waddr_i    (wa),
    .wr_i       (wr),
    .rdata_o    (rd)
  );

  always_comb begin
    logic                 ie;
    logic                 pd;
    logic                 zr;
    logic signed [IW+1:0] dec;
    logic signed [IW+1:0] endm;
    st_d = st_q;  end_d = end_q;  ov_d = ov_q;  init_len_d = init_len_q;
    idx_d = idx_q;  m_d = m_q;  sz_d = sz_q;  start_d = start_q;  len_d = len_q;
    startl_d = startl_q;  lenl_d = lenl_q;  lenr_d = lenr_q;
    lf_d = lf_q;  rf_d = rf_q;  wp_d = wp_q;
    k_d = k_q;  pm_d = pm_q;  gap_d = gap_q;  fo_d = fo_q;
    res_off_d = res_off_q;  res_st_d = res_st_q;
    rd_en = 1'b0;  ra = idx_q;  wa = idx_q;  wr = '0;
    tbl_clr = 1'b0;  rnd_start = 1'b0;
    ie = 1'b0;  pd = 1'b0;  zr = 1'b0;  dec = '0;  endm = '0;
    if (ov_q && rsp_o.ready) ov_d = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          res_off_d = '0;
          res_st_d  = ffpa_pkg::STAT_OK;
          fo_d      = req_i.free_offset;
          idx_d     = '0;
          priority if (req_i.func == ffpa_pkg::FUNC_ALLOC) begin
            rnd_start = 1'b1;
            st_d      = S_RND;
          end else if (req_i.func == ffpa_pkg::FUNC_FREE) begin
            st_d = S_FRD;
          end else if (req_i.func == ffpa_pkg::FUNC_INIT) begin
            tbl_clr    = 1'b1;
            init_len_d = (pool_len_q < LIM) ? pool_len_q : LIM;
            end_d      = '1;
            st_d       = S_DONE;
          end else begin
            st_d = S_DONE;
          end
        end
      end
      S_RND: begin
        if (rnd_done) begin
          sz_d = rnd_sz;
          st_d = S_ARD;
        end
      end
      S_ARD: begin
        rd_en = 1'b1;
        st_d  = S_ACHK;
      end
      S_ACHK: begin
        if (!rd.used && (sz_q <= {1'b0, rd.data.len})) begin
          res_off_d = rd.data.start[ffpa_pkg::OFF_W-1:0];
          start_d   = rd.data.start;
          len_d     = rd.data.len;
          st_d      = S_DONE;
          if (!(sz_q < {1'b0, rd.data.len})) begin
            wr.u_we = 1'b1;
            wr.used = 1'b1;
            if (end_s < idx_s) end_d = {1'b0, idx_q};
          end else if (idx_q == LAST) begin
            wr.u_we = 1'b1;
            wr.used = 1'b1;
            end_d   = NM1[IW:0];
          end else if (e1 == idx_s) begin
            // split at the tail: remainder becomes the new next entry
            wr.d_we = 1'b1;
            wr.u_we = 1'b1;
            wr.data = {rd.data.start, sz_q[LW-1:0]};
            wr.used = 1'b1;
            end_d   = {1'b0, idx_q};
            st_d    = S_ATAIL;
          end else if (end_s == NM1 || e1 == NM1) begin
            wr.u_we = 1'b1;
            wr.used = 1'b1;
          end else if (e1 < idx_s) begin
            // nothing above to move up
            st_d = S_GWI;
          end else begin
            m_d  = e1[IW-1:0];
            st_d = S_SRD;
          end
        end else if (idx_q == LAST) begin
          res_st_d = ffpa_pkg::STAT_NOFIT;
          st_d     = S_DONE;
        end else begin
          idx_d = idx_q + IW'(1);
          st_d  = S_ARD;
        end
      end
      S_ATAIL: begin
        wa      = idx_q + IW'(1);
        wr.d_we = 1'b1;
        wr.data = {start_q + sz_q[LW-1:0], len_q - sz_q[LW-1:0]};
        st_d    = S_DONE;
      end
      S_SRD: begin
        rd_en = 1'b1;
        ra    = m_q;
        st_d  = S_SWR;
      end
      S_SWR: begin
        wa      = m_q + IW'(1);
        wr.d_we = 1'b1;
        wr.u_we = 1'b1;
        wr.data = rd.data;
        wr.used = rd.used;
        if (m_q == idx_q + IW'(1)) begin
          st_d = S_GWI;
        end else begin
          m_d  = m_q - IW'(1);
          st_d = S_SRD;
        end
      end
      S_GWI: begin
        wr.d_we = 1'b1;
        wr.u_we = 1'b1;
        wr.data = {start_q, sz_q[LW-1:0]};
        wr.used = 1'b1;
        st_d    = S_GWN;
      end
      S_GWN: begin
        wa      = idx_q + IW'(1);
        wr.d_we = 1'b1;
        wr.u_we = 1'b1;
        wr.data = {start_q + sz_q[LW-1:0], len_q - sz_q[LW-1:0]};
        wr.used = 1'b0;
        end_d   = e1[IW:0];
        st_d    = S_DONE;
      end
      S_FRD: begin
        rd_en = 1'b1;
        st_d  = S_FCHK;
      end
      S_FCHK: begin
        if (rd.used && (rd.data.start == {1'b0, fo_q})) begin
          start_d = rd.data.start;
          len_d   = rd.data.len;
          lf_d    = 1'b0;
          rf_d    = 1'b0;
          st_d    = S_RRL;
        end else if (idx_q == LAST) begin
          res_st_d = ffpa_pkg::STAT_NOTFOUND;
          st_d     = S_DONE;
        end else begin
          idx_d = idx_q + IW'(1);
          st_d  = S_FRD;
        end
      end
      S_RRL: begin
        if (idx_q != '0) begin
          rd_en = 1'b1;
          ra    = idx_q - IW'(1);
          st_d  = S_RGL;
        end else begin
          st_d = S_RRR;
        end
      end
      S_RGL: begin
        lf_d     = !rd.used;
        startl_d = rd.data.start;
        lenl_d   = rd.data.len;
        st_d     = S_RRR;
      end
      S_RRR: begin
        if (idx_q != LAST) begin
          rd_en = 1'b1;
          ra    = idx_q + IW'(1);
          st_d  = S_RGR;
        end else begin
          st_d = S_RACT;
        end
      end
      S_RGR: begin
        rf_d   = !rd.used;
        lenr_d = rd.data.len;
        st_d   = S_RACT;
      end
      S_RACT: begin
        ie   = (end_s == idx_s);
        pm_d = e1;
        wp_d = 1'b0;
        priority if (lf_q && rf_q) begin
          wa      = idx_q - IW'(1);
          wr.d_we = 1'b1;
          wr.data = {startl_q, lenl_q + len_q + lenr_q};
          dec     = (IW+2)'(2);
          if (ie) begin
            zr   = 1'b1;
            wp_d = 1'b1;
          end else begin
            pd    = 1'b1;
            k_d   = idx_s;
            gap_d = 2'd2;
          end
        end else if (lf_q) begin
          wa      = idx_q - IW'(1);
          wr.d_we = 1'b1;
          wr.data = {startl_q, lenl_q + len_q};
          if (ie) begin
            wp_d = 1'b1;
            dec  = (IW+2)'(2);
          end else begin
            pd    = 1'b1;
            k_d   = idx_s;
            gap_d = 2'd1;
            dec   = (IW+2)'(1);
          end
        end else if (rf_q) begin
          wr.d_we = 1'b1;
          wr.u_we = 1'b1;
          wr.data = {start_q, len_q + lenr_q};
          wr.used = 1'b0;
          dec     = (IW+2)'(1);
          if (ie) begin
            zr = 1'b1;
          end else begin
            pd    = 1'b1;
            k_d   = idx_s + (IW+2)'(1);
            gap_d = 2'd1;
          end
        end else begin
          wr.u_we = 1'b1;
          wr.used = 1'b0;
          dec     = ie ? (IW+2)'(1) : ZERO;
        end
        endm = end_s - dec;
        if (endm < NEG1) endm = NEG1;
        end_d = endm[IW:0];
        priority if (pd) st_d = S_PCHK;
        else if (zr) st_d = S_RZR;
        else if (wp_d) st_d = S_RWP;
        else st_d = S_DONE;
      end
      S_RZR: begin
        // start and length only; the used mark stays
        wa      = idx_q + IW'(1);
        wr.d_we = 1'b1;
        st_d    = wp_q ? S_RWP : S_DONE;
      end
      S_RWP: begin
        wr.d_we = 1'b1;
        wr.u_we = 1'b1;
        st_d    = S_DONE;
      end
      S_PCHK: begin
        if (k_q < pm_q) begin
          if (kg >= NS) begin
            wa      = k_q[IW-1:0];
            wr.d_we = 1'b1;
            wr.u_we = 1'b1;
            k_d     = k_q + (IW+2)'(1);
          end else begin
            rd_en = 1'b1;
            ra    = kg[IW-1:0];
            st_d  = S_PWR;
          end
        end else begin
          if (pm_q >= ZERO && pm_q < NS) begin
            wa      = pm_q[IW-1:0];
            wr.d_we = 1'b1;
          end
          st_d = S_DONE;
        end
      end
      S_PWR: begin
        wa      = k_q[IW-1:0];
        wr.d_we = 1'b1;
        wr.u_we = 1'b1;
        wr.data = rd.data;
        wr.used = rd.used;
        k_d     = k_q + (IW+2)'(1);
        st_d    = S_PCHK;
      end
      S_DONE: begin
        ov_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      end_q      <= '1;
      ov_q       <= 1'b0;
      pool_len_q <= LIM;
      init_len_q <= LIM;
    end else begin
      st_q       <= st_d;
      end_q      <= end_d;
      ov_q       <= ov_d;
      init_len_q <= init_len_d;
      if (cfg_we_i) pool_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    m_q       <= m_d;
    sz_q      <= sz_d;
    start_q   <= start_d;
    len_q     <= len_d;
    startl_q  <= startl_d;
    lenl_q    <= lenl_d;
    lenr_q    <= lenr_d;
    lf_q      <= lf_d;
    rf_q      <= rf_d;
    wp_q      <= wp_d;
    k_q       <= k_d;
    pm_q      <= pm_d;
    gap_q     <= gap_d;
    fo_q      <= fo_d;
    res_off_q <= res_off_d;
    res_st_q  <= res_st_d;
  end

  `FFPA_ASSERT(a_end_range, (end_q[IW] == 1'b0) || (&end_q), "end index below minus one")
  `FFPA_ASSERT(a_no_rw_clash, (rd_en && (wr.d_we || wr.u_we)) |-> (ra != wa), "read and write hit one entry")
  `FFPA_ASSERT(a_accept_busy, in_acc |=> (st_q != S_IDLE), "accepted word not started")
  `FFPA_NEVER(a_rsp_overrun, ov_q && (st_q == S_DONE), "response register overrun")
endmodule

// File: rtl/core/ffpa_ram.sv
// Generic single write, single read RAM with registered read data.
module ffpa_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// File: rtl/core/ffpa_table.sv
// Partition table: data and used-mark RAMs with per-entry valid bits.
module ffpa_table #(
  parameter int N = 32,
  localparam int AW = $clog2(N)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  logic [ffpa_pkg::LEN_W-1:0] init_len_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  input  logic [AW-1:0]              waddr_i,
  input  ffpa_pkg::tbl_wr_t          wr_i,
  output ffpa_pkg::ent_t             rdata_o
);
  localparam int DW = $bits(ffpa_pkg::ent_data_t);

  logic [N-1:0]  dval_q;
  logic [N-1:0]  uval_q;
  logic          rdv_q;
  logic          ruv_q;
  logic          rz_q;
  logic [DW-1:0] d_rd;
  logic [0:0]    u_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dval_q <= '0;
      uval_q <= '0;
      rdv_q  <= 1'b0;
      ruv_q  <= 1'b0;
      rz_q   <= 1'b0;
    end else begin
      if (clr_i) begin
        dval_q <= '0;
        uval_q <= '0;
      end else begin
        if (wr_i.d_we) dval_q[waddr_i] <= 1'b1;
        if (wr_i.u_we) uval_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rdv_q <= dval_q[raddr_i];
        ruv_q <= uval_q[raddr_i];
        rz_q  <= (raddr_i == '0);
      end
    end
  end

  ffpa_ram #(.WIDTH(DW), .DEPTH(N)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.d_we),
    .waddr_i (waddr_i),
    .wdata_i (wr_i.data),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (d_rd)
  );

  ffpa_ram #(.WIDTH(1), .DEPTH(N)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.u_we),
    .waddr_i (waddr_i),
    .wdata_i (wr_i.used),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (u_rd)
  );

  // never-written entries read as the reinit image
  assign rdata_o.data = rdv_q ? ffpa_pkg::ent_data_t'(d_rd) :
                        (rz_q ? {{ffpa_pkg::LEN_W{1'b0}}, init_len_i} : '0);
  assign rdata_o.used = ruv_q & u_rd[0];
endmodule

// File: rtl/core/ffpa_round.sv
// Rounds a request up to the granule by reciprocal multiplication; the result is registered.
module ffpa_round #(
  parameter int GRANULE = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ffpa_pkg::LEN_W-1:0]  req_i,
  output logic                        done_o,
  output logic [ffpa_pkg::SZ_W-1:0]   sz_o
);
  localparam int SW = ffpa_pkg::SZ_W;
  localparam int L  = $clog2(GRANULE);
  localparam int S  = SW + L;
  localparam int MW = SW + 2;
  localparam int PW = SW + MW;
  localparam int GW = $clog2(GRANULE + 1);
  // exact floor(n / GRANULE) for every n below 2**SW
  localparam logic [MW-1:0] M =
    MW'(((longint'(1) << S) + longint'(GRANULE) - 1) / longint'(GRANULE));

  logic                done_q;
  logic [SW-1:0]       sz_q;
  logic [SW-1:0]       sum;
  logic [PW-1:0]       prod;
  logic [SW-1:0]       quo;
  logic [SW+GW-1:0]    back;

  assign sum  = {1'b0, req_i} + SW'(GRANULE - 1);
  assign prod = PW'(sum) * PW'(M);
  assign quo  = SW'(prod >> S);
  assign back = (SW+GW)'(quo) * (SW+GW)'(GRANULE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sz_q <= back[SW-1:0];
    end
  end

  assign done_o = done_q;
  assign sz_o   = sz_q;
endmodule
